@@ hdl/sgr_pkg.sv @@
// ----------------------------------------------------------------------------
// sgr_pkg: shared definitions for the swipe gesture recogniser
// Event kinds, direction codes and the fixed field widths of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package sgr_pkg;

  // Field widths fixed by the event and result formats.
  localparam int unsigned KindW  = 2;
  localparam int unsigned CoordW = 16;
  localparam int unsigned DeltaW = CoordW + 1;
  localparam int unsigned SqW    = 2 * CoordW;
  localparam int unsigned DirW   = 2;
  localparam int unsigned ThrW   = 16;

  // Event kinds carried on the input tuser.
  localparam logic [KindW-1:0] KIND_START  = 2'd0;
  localparam logic [KindW-1:0] KIND_POINT  = 2'd1;
  localparam logic [KindW-1:0] KIND_FINISH = 2'd2;

  // Stroke direction codes.
  localparam logic [DirW-1:0] DIR_UP    = 2'd0;
  localparam logic [DirW-1:0] DIR_DOWN  = 2'd1;
  localparam logic [DirW-1:0] DIR_RIGHT = 2'd2;
  localparam logic [DirW-1:0] DIR_LEFT  = 2'd3;

endpackage

`default_nettype wire

@@ hdl/swipe_gesture_recognizer.sv @@
// ----------------------------------------------------------------------------
// swipe_gesture_recognizer: pointer events to swipe directions
// Measures pointer movement against an anchor and keeps a short stroke list.
// ----------------------------------------------------------------------------
// A start word arms the block and sets the anchor. For a position word the
// threshold is squared in the cycle it is accepted; then dx and dy are
// squared in turn on the one shared multiplier, and the sum is compared and
// classified in the same cycle as dy is squared. A position that appends a
// direction then hands its word to the output register in ST_EMIT once the
// output is free. A finish word lists the stored directions, each fetched by
// the registered read of the stroke memory and then handed out, or sends a
// single empty-gesture word. The input is not ready while a word is being
// worked on, but it is ready while a finished result waits on the output.
// The threshold register may be written at any time the block is idle.
`default_nettype none

module swipe_gesture_recognizer #(
  parameter int unsigned MAX_STROKES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Threshold register write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  // Event input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [15:0] pos_x, [31:16] pos_y
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] kind
  // Result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [1:0] direction, [7:2] zero
  output logic [1:0]       m_axis_tuser,  // [0] report, [1] empty_gesture
  output logic             m_axis_tlast   // is_last
);
  import sgr_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_STROKES + 1);
  localparam int unsigned IdxW = (MAX_STROKES > 1) ? $clog2(MAX_STROKES) : 1;

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQX  = 3'd1;
  localparam logic [2:0] ST_SQY  = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_LOUT = 3'd5;

  logic [2:0]              state_q, state_d;
  logic                    armed_q, armed_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [ThrW-1:0]         thr_q, thr_d;
  logic [CoordW-1:0]       anchor_x_q, anchor_x_d;
  logic [CoordW-1:0]       anchor_y_q, anchor_y_d;
  logic [DirW-1:0]         last_dir_q, last_dir_d;
  logic signed [DeltaW-1:0] dx_q, dx_d;
  logic signed [DeltaW-1:0] dy_q, dy_d;
  logic [SqW-1:0]          acc_q, acc_d;
  logic [SqW-1:0]          thr2_q, thr2_d;
  logic [DirW-1:0]         pend_dir_q, pend_dir_d;
  logic                    pend_fin_q, pend_fin_d;
  logic                    out_valid_q, out_valid_d;
  logic [DirW-1:0]         out_dir_q, out_dir_d;
  logic                    out_rep_q, out_rep_d;
  logic                    out_last_q, out_last_d;
  logic                    out_empty_q, out_empty_d;

  logic [DirW-1:0]         store_mem [MAX_STROKES];
  logic [DirW-1:0]         rd_q;
  logic                    store_we;

  logic                    accept;
  logic                    out_free;
  logic [KindW-1:0]        in_kind;
  logic [CoordW-1:0]       in_x, in_y;
  logic signed [DeltaW-1:0] sq_op;
  logic [SqW-1:0]          sq;
  logic [SqW:0]            dist2;
  logic                    far;
  logic [DeltaW-1:0]       abs_x, abs_y;
  logic [DeltaW:0]         twice_x, twice_y;
  logic                    dir_ok;
  logic [DirW-1:0]         dir;
  logic                    list_last;

  // Handshakes and input unpacking.
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign in_kind       = s_axis_tuser;
  assign in_x          = s_axis_tdata[15:0];
  assign in_y          = s_axis_tdata[31:16];

  // Operand selection for the shared squaring unit.
  always_comb begin
    unique case (state_q)
      ST_SQX:  sq_op = dx_q;
      ST_SQY:  sq_op = dy_q;
      default: sq_op = $signed({1'b0, thr_q});
    endcase
  end

  sgr_square u_square (
    .op_i (sq_op),
    .sq_o (sq)
  );

  // Distance test and classification of the movement in the last step.
  assign dist2   = {1'b0, acc_q} + {1'b0, sq};
  assign far     = dist2 > {1'b0, thr2_q};
  assign abs_x   = dx_q[DeltaW-1] ? DeltaW'(-dx_q) : DeltaW'(dx_q);
  assign abs_y   = dy_q[DeltaW-1] ? DeltaW'(-dy_q) : DeltaW'(dy_q);
  assign twice_x = {abs_x, 1'b0};
  assign twice_y = {abs_y, 1'b0};

  always_comb begin
    dir_ok = 1'b1;
    priority if (dy_q < 0 && {1'b0, abs_y} >= twice_x) begin
      dir = DIR_UP;
    end else if (dy_q > 0 && {1'b0, abs_y} >= twice_x) begin
      dir = DIR_DOWN;
    end else if (dx_q > 0 && {1'b0, abs_x} >= twice_y) begin
      dir = DIR_RIGHT;
    end else if (dx_q < 0 && {1'b0, abs_x} >= twice_y) begin
      dir = DIR_LEFT;
    end else begin
      dir    = DIR_UP;
      dir_ok = 1'b0;
    end
  end

  assign list_last = (CntW'(idx_q) + CntW'(1)) == count_q;

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d     = state_q;
    armed_d     = armed_q;
    count_d     = count_q;
    idx_d       = idx_q;
    thr_d       = thr_q;
    anchor_x_d  = anchor_x_q;
    anchor_y_d  = anchor_y_q;
    last_dir_d  = last_dir_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    acc_d       = acc_q;
    thr2_d      = thr2_q;
    pend_dir_d  = pend_dir_q;
    pend_fin_d  = pend_fin_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_dir_d   = out_dir_q;
    out_rep_d   = out_rep_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    store_we    = 1'b0;

    if (cfg_valid_i) begin
      thr_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          thr2_d = sq;
          dx_d   = $signed({in_x[CoordW-1], in_x}) - $signed({anchor_x_q[CoordW-1], anchor_x_q});
          dy_d   = $signed({in_y[CoordW-1], in_y}) - $signed({anchor_y_q[CoordW-1], anchor_y_q});
          if (in_kind == KIND_START) begin
            armed_d    = 1'b1;
            anchor_x_d = in_x;
            anchor_y_d = in_y;
            count_d    = '0;
          end else if (in_kind == KIND_POINT) begin
            if (armed_q) begin
              state_d = ST_SQX;
            end
          end else if (in_kind == KIND_FINISH) begin
            armed_d = 1'b0;
            idx_d   = '0;
            if (count_q == '0) begin
              pend_fin_d = 1'b1;
              pend_dir_d = DIR_UP;
              state_d    = ST_EMIT;
            end else begin
              state_d = ST_RD;
            end
          end
        end
      end
      ST_SQX: begin
        acc_d   = sq;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        state_d = ST_IDLE;
        if (far) begin
          anchor_x_d = anchor_x_q + dx_q[CoordW-1:0];
          anchor_y_d = anchor_y_q + dy_q[CoordW-1:0];
          if (dir_ok && count_q < CntW'(MAX_STROKES) &&
              (count_q == '0 || last_dir_q != dir)) begin
            store_we   = 1'b1;
            count_d    = count_q + CntW'(1);
            last_dir_d = dir;
            pend_dir_d = dir;
            pend_fin_d = 1'b0;
            state_d    = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dir_d   = pend_dir_q;
          out_rep_d   = pend_fin_q;
          out_last_d  = pend_fin_q;
          out_empty_d = pend_fin_q;
          state_d     = ST_IDLE;
        end
      end
      ST_RD: begin
        // The memory read of entry idx_q lands in rd_q at this edge.
        state_d = ST_LOUT;
      end
      ST_LOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dir_d   = rd_q;
          out_rep_d   = 1'b1;
          out_last_d  = list_last;
          out_empty_d = 1'b0;
          if (list_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      thr_q       <= '0;
      anchor_x_q  <= '0;
      anchor_y_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      thr_q       <= thr_d;
      anchor_x_q  <= anchor_x_d;
      anchor_y_q  <= anchor_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and the output word.
  always_ff @(posedge clk_i) begin
    last_dir_q  <= last_dir_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    acc_q       <= acc_d;
    thr2_q      <= thr2_d;
    pend_dir_q  <= pend_dir_d;
    pend_fin_q  <= pend_fin_d;
    out_dir_q   <= out_dir_d;
    out_rep_q   <= out_rep_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  // Stroke memory: one write port at the fill count, one registered read.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[count_q[IdxW-1:0]] <= dir;
    end
    rd_q <= store_mem[idx_q];
  end

  // Output packing.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_dir_q};
  assign m_axis_tuser  = {out_empty_q, out_rep_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ hdl/sgr_square.sv @@
// ----------------------------------------------------------------------------
// sgr_square: shared squaring unit
// Squares a signed delta or a zero-extended threshold. The magnitude never
// exceeds 65535, so the square always fits in 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_square (
  input  wire logic signed [sgr_pkg::DeltaW-1:0] op_i,
  output logic             [sgr_pkg::SqW-1:0]    sq_o
);
  import sgr_pkg::*;

  logic signed [2*DeltaW-1:0] prod;

  // One signed multiplier; the upper bits are always zero for legal operands.
  assign prod = op_i * op_i;
  assign sq_o = prod[SqW-1:0];

endmodule

`default_nettype wire

@@ hdl/sgr_checker.sv @@
// ----------------------------------------------------------------------------
// sgr_checker: port-level checks for the swipe gesture recogniser
// Watches the result channel and the input handshake over time.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [1:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  // A stalled result word keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // An empty gesture is a one-word finish listing with direction zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tuser[0] && m_axis_tlast && m_axis_tdata == 8'd0)
    else $error("malformed empty-gesture word");

  // Drag reports never carry the end-of-listing marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tlast && !m_axis_tuser[1])
    else $error("drag report marked as listing end");

  // A result word that waits while an event is accepted is still offered in
  // the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid)
    else $error("pending result lost while an event was accepted");

endmodule

bind swipe_gesture_recognizer sgr_checker u_sgr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ dv/swipe_gesture_recognizer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swipe_gesture_recognizer_test: self-checking bench for the swipe recogniser
// Drives start, position and finish words with random gaps, predicts every
// result word from its own copy of the gesture state, and compares each word
// on the output stream against the oldest prediction, field by field.
// ----------------------------------------------------------------------------

module swipe_gesture_recognizer_test;

  import sgr_pkg::*;

  localparam int unsigned MaxStrokes = 8;
  // Kind code that the block must ignore.
  localparam logic [KindW-1:0] KIND_UNKNOWN = 2'd3;
  // Cycles to let pass after the last awaited word before the block is idle.
  localparam int unsigned SettleCycles = 12;

  // One result word as it should leave the block.
  typedef struct packed {
    logic            report;
    logic [DirW-1:0] direction;
    logic            is_last;
    logic            empty_gesture;
  } stroke_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             thr_valid = 1'b0;
  logic [ThrW-1:0]  thr_data = '0;
  logic             thr_ready;
  logic             ev_valid = 1'b0;
  logic             ev_ready;
  logic [CoordW-1:0] ev_x = '0;
  logic [CoordW-1:0] ev_y = '0;
  logic [KindW-1:0] ev_kind = KIND_START;
  logic             res_valid;
  logic             res_ready = 1'b0;
  logic [7:0]       res_data;
  logic [1:0]       res_user;
  logic             res_last;

  // Gap and stall rates in percent, changed from phase to phase.
  int unsigned event_gap_pct = 0;
  int unsigned result_stall_pct = 0;

  int unsigned mismatches = 0;
  int unsigned events_applied = 0;

  // Predicted gesture state.
  logic [ThrW-1:0]          move_threshold = '0;
  bit                       armed = 1'b0;
  logic signed [CoordW-1:0] anchor_x = '0;
  logic signed [CoordW-1:0] anchor_y = '0;
  logic [DirW-1:0]          stroke_store [MaxStrokes];
  int unsigned              stroke_count = 0;

  stroke_word_t awaited_words [$];

  swipe_gesture_recognizer #(
    .MAX_STROKES(MaxStrokes)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (thr_valid),
    .cfg_ready_o  (thr_ready),
    .cfg_data_i   (thr_data),
    .s_axis_tvalid(ev_valid),
    .s_axis_tready(ev_ready),
    .s_axis_tdata ({ev_y, ev_x}),  // [15:0] pos_x, [31:16] pos_y
    .s_axis_tuser (ev_kind),       // [1:0] kind
    .m_axis_tvalid(res_valid),
    .m_axis_tready(res_ready),
    .m_axis_tdata (res_data),      // [1:0] direction, [7:2] zero
    .m_axis_tuser (res_user),      // [0] report, [1] empty_gesture
    .m_axis_tlast (res_last)       // is_last
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random at the current rate.
  always @(negedge clk) begin
    res_ready <= ($urandom_range(99) >= result_stall_pct);
  end

  // Prints one line per mismatch and counts it.
  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned wanted);
    $display("%0t ns: %s: got %0d, wanted %0d", $time, what, got, wanted);
    mismatches++;
  endtask

  // Applies one event to the predicted state and queues the words it causes.
  // Returns zero only for an unknown kind or for a position while not armed.
  function automatic bit recognise_event(input logic [KindW-1:0] kind,
                                         input logic signed [CoordW-1:0] px,
                                         input logic signed [CoordW-1:0] py);
    longint dx;
    longint dy;
    longint ax;
    longint ay;
    longint dist2;
    longint thr2;
    logic [DirW-1:0] dir;
    bit clear;
    int unsigned i;

    case (kind)
      KIND_START: begin
        armed = 1'b1;
        anchor_x = px;
        anchor_y = py;
        stroke_count = 0;
        return 1'b1;
      end
      KIND_POINT: begin
        if (!armed) begin
          return 1'b0;
        end
        dx = longint'(px) - longint'(anchor_x);
        dy = longint'(py) - longint'(anchor_y);
        dist2 = dx * dx + dy * dy;
        thr2 = longint'(move_threshold) * longint'(move_threshold);
        if (dist2 <= thr2) begin
          return 1'b1;
        end
        // The point counts, so it becomes the anchor whatever its direction.
        anchor_x = px;
        anchor_y = py;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        clear = 1'b1;
        dir = DIR_UP;
        if (dy < 0 && -dy >= 2 * ax) begin
          dir = DIR_UP;
        end else if (dy > 0 && dy >= 2 * ax) begin
          dir = DIR_DOWN;
        end else if (dx > 0 && dx >= 2 * ay) begin
          dir = DIR_RIGHT;
        end else if (dx < 0 && -dx >= 2 * ay) begin
          dir = DIR_LEFT;
        end else begin
          clear = 1'b0;
        end
        if (clear && stroke_count < MaxStrokes &&
            (stroke_count == 0 || stroke_store[stroke_count-1] != dir)) begin
          stroke_store[stroke_count] = dir;
          stroke_count++;
          awaited_words.push_back('{report: 1'b0, direction: dir,
                                    is_last: 1'b0, empty_gesture: 1'b0});
        end
        return 1'b1;
      end
      KIND_FINISH: begin
        // The list survives a finish, so a second finish lists it again.
        armed = 1'b0;
        if (stroke_count == 0) begin
          awaited_words.push_back('{report: 1'b1, direction: DIR_UP,
                                    is_last: 1'b1, empty_gesture: 1'b1});
        end
        for (i = 0; i < stroke_count; i++) begin
          awaited_words.push_back('{report: 1'b1, direction: stroke_store[i],
                                    is_last: (i + 1 == stroke_count),
                                    empty_gesture: 1'b0});
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Sends one event word after a random gap; returns at the falling edge
  // after acceptance with the valid still high.
  task automatic send_event(input logic [KindW-1:0] kind,
                            input logic [CoordW-1:0] x,
                            input logic [CoordW-1:0] y);
    while ($urandom_range(99) < event_gap_pct) begin
      ev_valid <= 1'b0;
      @(negedge clk);
    end
    ev_valid <= 1'b1;
    ev_kind <= kind;
    ev_x <= x;
    ev_y <= y;
    do @(posedge clk); while (!ev_ready);
    @(negedge clk);
    if (recognise_event(kind, x, y)) begin
      events_applied++;
    end
  endtask

  // Stops sending, waits for every awaited word and lets the block settle.
  task automatic wait_for_idle();
    ev_valid <= 1'b0;
    while (awaited_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [ThrW-1:0] value);
    wait_for_idle();
    thr_valid <= 1'b1;
    thr_data <= value;
    do @(posedge clk); while (!thr_ready);
    @(negedge clk);
    thr_valid <= 1'b0;
    move_threshold = value;
  endtask

  // Each accepted result word is compared against the oldest prediction.
  always @(posedge clk) begin
    stroke_word_t want;
    if (rst_n && res_valid && res_ready) begin
      if (awaited_words.size() == 0) begin
        flag_mismatch("result word with none awaited", res_data, 0);
      end else begin
        want = awaited_words.pop_front();
        if (res_user[0] !== want.report) begin
          flag_mismatch("report", res_user[0], want.report);
        end
        if (res_data !== {6'b0, want.direction}) begin
          flag_mismatch("direction word", res_data, want.direction);
        end
        if (res_last !== want.is_last) begin
          flag_mismatch("is_last", res_last, want.is_last);
        end
        if (res_user[1] !== want.empty_gesture) begin
          flag_mismatch("empty_gesture", res_user[1], want.empty_gesture);
        end
      end
    end
  end

  // Finish before any start, then events that must be ignored.
  task automatic test_empty_and_ignored();
    send_event(KIND_FINISH, 16'h0000, 16'h0000);
    send_event(KIND_POINT, 16'd5, 16'd5);
    send_event(KIND_UNKNOWN, 16'hFFFF, 16'hFFFF);
  endtask

  // Every direction, repeated directions and a move on the two-to-one boundary at
  // zero threshold. The gesture is left armed for the next test.
  task automatic test_drag_directions();
    send_event(KIND_START, 16'd0, 16'd0);
    send_event(KIND_POINT, 16'd0, -16'sd10);
    send_event(KIND_POINT, 16'd0, -16'sd20);
    send_event(KIND_POINT, 16'd10, -16'sd20);
    send_event(KIND_POINT, 16'd12, -16'sd19);
    send_event(KIND_POINT, 16'd12, -16'sd9);
    send_event(KIND_POINT, 16'd2, -16'sd9);
  endtask

  // A start while armed clears the list; nine alternating strokes overfill it.
  task automatic test_full_stroke_list();
    int unsigned k;
    send_event(KIND_START, 16'h8000, 16'h7FFF);
    for (k = 0; k < 9; k++) begin
      send_event(KIND_POINT, 16'h8000, (k % 2 == 0) ? 16'h7FFB : 16'h7FFF);
    end
    send_event(KIND_FINISH, 16'h1234, 16'hEDCB);
  endtask

  // Largest threshold against the largest moves, then a small threshold
  // with moves exactly on the distance and the two-to-one boundaries.
  task automatic test_threshold_extremes();
    write_threshold(16'hFFFF);
    send_event(KIND_START, 16'h8000, 16'h8000);
    send_event(KIND_POINT, 16'h7FFF, 16'h8001);
    send_event(KIND_POINT, 16'h8000, 16'h8001);
    send_event(KIND_FINISH, 16'h0000, 16'h0000);
    write_threshold(16'd5);
    send_event(KIND_START, 16'd0, 16'd0);
    send_event(KIND_POINT, 16'd3, 16'd4);
    send_event(KIND_POINT, 16'd3, 16'd6);
    send_event(KIND_POINT, 16'd9, 16'd3);
    send_event(KIND_FINISH, 16'd0, 16'd0);
  endtask

  // One gesture: a start, a random walk of moves around the threshold, and
  // usually a finish.
  task automatic drive_gesture();
    logic [CoordW-1:0] cur_x;
    logic [CoordW-1:0] cur_y;
    int thr;
    int mag;
    int across;
    int dx;
    int dy;
    int unsigned moves;

    thr = int'(move_threshold);
    cur_x = CoordW'($urandom_range(32000) - 16000);
    cur_y = CoordW'($urandom_range(32000) - 16000);
    send_event(KIND_START, cur_x, cur_y);
    moves = $urandom_range(1, 12);
    repeat (moves) begin
      if ($urandom_range(3) == 0) begin
        mag = $urandom_range(thr);
      end else begin
        mag = thr + 1 + $urandom_range(thr + 40);
      end
      across = $urandom_range(mag * 3 / 4);
      if ($urandom_range(1) == 1) begin
        across = -across;
      end
      case ($urandom_range(4))
        0: begin dx = across; dy = -mag; end
        1: begin dx = across; dy = mag; end
        2: begin dx = mag; dy = across; end
        3: begin dx = -mag; dy = across; end
        default: begin
          dx = $urandom_range(2 * mag) - mag;
          dy = $urandom_range(2 * mag) - mag;
        end
      endcase
      cur_x = cur_x + CoordW'(dx);
      cur_y = cur_y + CoordW'(dy);
      send_event(KIND_POINT, cur_x, cur_y);
    end
    if ($urandom_range(9) != 0) begin
      send_event(KIND_FINISH, CoordW'($urandom), CoordW'($urandom));
    end
    if ($urandom_range(9) == 0) begin
      send_event(KIND_FINISH, CoordW'($urandom), CoordW'($urandom));
    end
  endtask

  // Random gestures mixed with noise words under one idling setting.
  task automatic test_random_gestures(input int unsigned gap_pct,
                                      input int unsigned stall_pct,
                                      input int unsigned thr_lo,
                                      input int unsigned thr_hi,
                                      input int unsigned count);
    int unsigned target;
    write_threshold(ThrW'($urandom_range(thr_hi, thr_lo)));
    event_gap_pct = gap_pct;
    result_stall_pct = stall_pct;
    target = events_applied + count;
    while (events_applied < target) begin
      if ($urandom_range(99) < 80) begin
        drive_gesture();
      end else begin
        send_event(KindW'($urandom_range(3)), CoordW'($urandom), CoordW'($urandom));
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_and_ignored();
    test_drag_directions();
    test_full_stroke_list();
    test_threshold_extremes();

    test_random_gestures(0, 0, 0, 0, 60);
    test_random_gestures(60, 0, 1, 30, 60);
    test_random_gestures(0, 60, 200, 3000, 60);
    test_random_gestures(19, 19, 1, 30, 60);

    wait_for_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/sgr_pkg.sv
hdl/sgr_square.sv
hdl/swipe_gesture_recognizer.sv
hdl/sgr_checker.sv
dv/swipe_gesture_recognizer_test.sv
